### hw/rtl/base64url_stream_decoder_top_defines.svh
// Assertion macros shared by the Base64 stream decoder modules.
`ifndef BASE64URL_STREAM_DECODER_TOP_DEFINES_SVH
`define BASE64URL_STREAM_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define B64_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("b64 assertion failed");

// Next-cycle implication, checked outside reset.
`define B64_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("b64 assertion failed");

`endif

### hw/rtl/b64_pkg.sv
// Types and constants for the Base64 stream decoder.
package b64_pkg;

   localparam logic [7:0] CHAR_PAD        = 8'h3D;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z    = 8'h7A;
   localparam logic [7:0] CHAR_DIGIT_0    = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9    = 8'h39;

   localparam logic [7:0] LOWER_OFFSET = 8'd26;
   localparam logic [7:0] DIGIT_OFFSET = 8'd52;
   localparam logic [5:0] SEXTET_62    = 6'd62;
   localparam logic [5:0] SEXTET_63    = 6'd63;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_FOURTH = 2'd3;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_message;
      logic       decode_error;
   } rsp_type;

   typedef struct packed {
      logic       is_data;
      logic       is_pad;
      logic [5:0] sextet;
   } sextet_info_type;

endpackage

### hw/rtl/b64_sextet_lut.sv
// Character classifier: maps one ASCII byte to its sextet value.
module b64_sextet_lut
   import b64_pkg::*;
(
   input  logic [7:0]      char_code,
   output sextet_info_type info
);

   logic [7:0] upper_val;
   logic [7:0] lower_val;
   logic [7:0] digit_val;

   assign upper_val = char_code - CHAR_UPPER_A;
   assign lower_val = char_code - CHAR_LOWER_A + LOWER_OFFSET;
   assign digit_val = char_code - CHAR_DIGIT_0 + DIGIT_OFFSET;

   always_comb begin
      info.is_data = 1'b0;
      info.is_pad  = 1'b0;
      info.sextet  = '0;
      if (char_code == CHAR_PAD) begin
         info.is_pad = 1'b1;
      end else if (char_code inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         info.is_data = 1'b1;
         info.sextet  = upper_val[5:0];
      end else if (char_code inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         info.is_data = 1'b1;
         info.sextet  = lower_val[5:0];
      end else if (char_code inside {[CHAR_DIGIT_0:CHAR_DIGIT_9]}) begin
         info.is_data = 1'b1;
         info.sextet  = digit_val[5:0];
      end else if (char_code inside {CHAR_PLUS, CHAR_MINUS}) begin
         info.is_data = 1'b1;
         info.sextet  = SEXTET_62;
      end else if (char_code inside {CHAR_SLASH, CHAR_UNDERSCORE}) begin
         info.is_data = 1'b1;
         info.sextet  = SEXTET_63;
      end
   end

endmodule

### hw/rtl/b64_decode_core.sv
// Message state and byte assembly for one character per step.
`include "base64url_stream_decoder_top_defines.svh"

module b64_decode_core
   import b64_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   output logic    has_result,
   output rsp_type result
);

   sextet_info_type info;

   logic [1:0] group_position_ff;
   logic [1:0] group_position_in;
   logic [5:0] previous_sextet_ff;
   logic [5:0] previous_sextet_in;
   logic       padding_seen_ff;
   logic       padding_seen_in;
   logic       error_seen_ff;
   logic       error_seen_in;
   logic       data_seen_ff;
   logic       data_seen_in;

   logic       have_byte;
   logic [7:0] byte_val;
   logic       state_idle;

   b64_sextet_lut u_lut (
      .char_code (item.char_code),
      .info      (info)
   );

   always_comb begin
      group_position_in  = group_position_ff;
      previous_sextet_in = previous_sextet_ff;
      padding_seen_in    = padding_seen_ff;
      error_seen_in      = error_seen_ff;
      data_seen_in       = data_seen_ff;
      have_byte          = 1'b0;
      byte_val           = '0;
      if (info.is_pad) begin
         padding_seen_in = 1'b1;
      end else if (!info.is_data || padding_seen_ff) begin
         error_seen_in = 1'b1;
      end else begin
         if (!error_seen_ff) begin
            case (group_position_ff)
               POS_SECOND: begin
                  byte_val  = {previous_sextet_ff, info.sextet[5:4]};
                  have_byte = 1'b1;
               end
               POS_THIRD: begin
                  byte_val  = {previous_sextet_ff[3:0], info.sextet[5:2]};
                  have_byte = 1'b1;
               end
               POS_FOURTH: begin
                  byte_val  = {previous_sextet_ff[1:0], info.sextet};
                  have_byte = 1'b1;
               end
               default: begin
                  have_byte = 1'b0;
               end
            endcase
         end
         previous_sextet_in = info.sextet;
         group_position_in  = group_position_ff + 2'd1;
         data_seen_in       = 1'b1;
      end
   end

   assign has_result            = have_byte || item.is_last;
   assign result.data_byte      = byte_val;
   assign result.byte_valid     = have_byte;
   assign result.end_of_message = item.is_last;
   assign result.decode_error   = item.is_last &&
                                  (error_seen_in || !data_seen_in ||
                                   group_position_in == POS_SECOND);

   assign state_idle = group_position_ff == POS_FIRST && !error_seen_ff &&
                       !padding_seen_ff && !data_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_position_ff  <= POS_FIRST;
         previous_sextet_ff <= '0;
         padding_seen_ff    <= 1'b0;
         error_seen_ff      <= 1'b0;
         data_seen_ff       <= 1'b0;
      end else if (step) begin
         if (item.is_last) begin
            group_position_ff  <= POS_FIRST;
            previous_sextet_ff <= '0;
            padding_seen_ff    <= 1'b0;
            error_seen_ff      <= 1'b0;
            data_seen_ff       <= 1'b0;
         end else begin
            group_position_ff  <= group_position_in;
            previous_sextet_ff <= previous_sextet_in;
            padding_seen_ff    <= padding_seen_in;
            error_seen_ff      <= error_seen_in;
            data_seen_ff       <= data_seen_in;
         end
      end
   end

   `B64_ASSERT_NEXT(a_clear_after_last, clock, reset, step && item.is_last, state_idle)
   `B64_ASSERT_NOW(a_no_byte_after_error, clock, reset, error_seen_ff, !result.byte_valid)
   `B64_ASSERT_NOW(a_no_byte_on_first, clock, reset, group_position_ff == POS_FIRST, !result.byte_valid)

endmodule

### hw/rtl/base64url_stream_decoder_top.sv
// Top level of the Base64 stream decoder: input register, decode core, result register.
// Takes one character per clock unless stalled and decodes both the standard and the
// URL-safe Base64 alphabets, with trailing '=' padding. Every data character after
// the first of a group of four yields one byte at once while no error or padding
// has been seen; a character flagged as the last one always yields a result
// carrying end_of_message and the verdict on the whole message. Throughput is one
// item per cycle while rsp_stall does not hold the result register: the character
// register feeds a small lookup and shift into the result register. Characters
// that decode to nothing produce no result.
`include "base64url_stream_decoder_top_defines.svh"

module base64url_stream_decoder_top
   import b64_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   logic    in_valid_ff;
   logic    in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_item_ff;

   logic    advance;
   logic    step;
   logic    has_result;
   rsp_type result;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = advance ? (step && has_result) : out_valid_ff;

   b64_decode_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .item       (in_item_ff),
      .has_result (has_result),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff <= req_item;
      end
      if (step && has_result) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   `B64_ASSERT_NOW(a_stall_only_when_blocked, clock, reset, req_stall, in_valid_ff && out_valid_ff && rsp_stall)
   `B64_ASSERT_NOW(a_result_has_content, clock, reset, rsp_valid, rsp_item.byte_valid || rsp_item.end_of_message)
   `B64_ASSERT_NOW(a_error_only_at_end, clock, reset, rsp_valid && !rsp_item.end_of_message, !rsp_item.decode_error)

endmodule
